@@ rtl/nds_pkg.sv @@
// ----------------------------------------------------------------------------
// nds_pkg: shared types, constants and code tables
// Digit storage type, divide-by-ten reciprocal and the driver code tables
// used by the decimal-to-serial encoder.
// ----------------------------------------------------------------------------
package nds_pkg;

  localparam int unsigned ValueW   = 20;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDiv   = 5;
  localparam int unsigned IdxW     = $clog2(NumDiv);
  localparam int unsigned WordW    = 24;
  localparam int unsigned CntW     = $clog2(WordW);
  localparam int unsigned Radix    = 10;
  localparam int unsigned DivShift = 23;

  // floor(x / 10) == (x * DivMul) >> DivShift for every x below 2**20
  localparam logic [ValueW-1:0] DivMul = ValueW'(838861);

  localparam logic [CntW-1:0] LastBit = CntW'(WordW - 1);

  typedef logic [DigitW-1:0] digit_t;
  typedef digit_t [NumDiv-1:0] digits_t;

  function automatic logic [3:0] digit_code(input digit_t d);
    logic [3:0] c;
    case (d)
      4'd0:    c = 4'b1000;
      4'd1:    c = 4'b0000;
      4'd2:    c = 4'b0100;
      4'd3:    c = 4'b0110;
      4'd4:    c = 4'b0010;
      4'd5:    c = 4'b0011;
      4'd6:    c = 4'b0111;
      4'd7:    c = 4'b0101;
      4'd8:    c = 4'b0001;
      4'd9:    c = 4'b1100;
      default: c = 4'b0000;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] high_code(input digit_t d);
    logic [3:0] c;
    case (d)
      4'd0:    c = 4'b0001;
      4'd1:    c = 4'b1000;
      4'd2:    c = 4'b0100;
      4'd3:    c = 4'b0010;
      default: c = 4'b0000;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] reorder4(input logic [3:0] c);
    return {c[2], c[0], c[1], c[3]};
  endfunction

  function automatic logic [7:0] move4(input logic [3:0] c);
    return {c[3], 4'b0000, c[2:0]};
  endfunction

  function automatic logic [7:0] place_plain(input logic [3:0] c);
    return {1'b0, c, 3'b000};
  endfunction

endpackage

@@ rtl/nds_div_stage.sv @@
// ----------------------------------------------------------------------------
// nds_div_stage: one divide-by-ten pipeline stage
// Splits off the lowest decimal digit of the incoming value with a reciprocal
// multiply, stores it at the given digit slot and passes the quotient on.
// ----------------------------------------------------------------------------
module nds_div_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [nds_pkg::ValueW-1:0] value_i,
  input  nds_pkg::digits_t          digits_i,
  input  logic [nds_pkg::IdxW-1:0]  idx_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [nds_pkg::ValueW-1:0] value_o,
  output nds_pkg::digits_t          digits_o
);
  import nds_pkg::*;

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   times10;
  logic [ValueW-1:0]   rem;
  digits_t             digits_d, digits_q;
  logic [ValueW-1:0]   value_d, value_q;
  logic                valid_d, valid_q;

  assign prod    = value_i * DivMul;
  assign quot    = ValueW'(prod[2*ValueW-1:DivShift]);
  assign times10 = (quot << 3) + (quot << 1);
  assign rem     = value_i - times10;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    digits_d        = digits_i;
    digits_d[idx_i] = rem[DigitW-1:0];
    value_d         = quot;
    valid_d         = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q  <= value_d;
      digits_q <= digits_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign digits_o = digits_q;

endmodule

@@ rtl/nds_encode.sv @@
// ----------------------------------------------------------------------------
// nds_encode: digit code stage
// Reduces the top quotient to the sixth digit, maps all digits through the
// driver code tables and registers the packed 24-bit word.
// ----------------------------------------------------------------------------
module nds_encode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [nds_pkg::ValueW-1:0] value_i,
  input  nds_pkg::digits_t           digits_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [nds_pkg::WordW-1:0]  word_o
);
  import nds_pkg::*;

  digit_t             d5;
  logic [7:0]         byte2, byte1, byte0;
  logic [WordW-1:0]   word_d, word_q;
  logic               valid_d, valid_q;

  always_comb begin
    if (value_i >= ValueW'(Radix)) begin
      d5 = DigitW'(value_i - ValueW'(Radix));
    end else begin
      d5 = value_i[DigitW-1:0];
    end
    byte2  = move4(reorder4(digit_code(digits_i[0]))) | place_plain(digit_code(digits_i[1]));
    byte1  = move4(reorder4(digit_code(digits_i[2]))) | place_plain(digit_code(digits_i[3]));
    byte0  = move4(high_code(d5)) | place_plain(digit_code(digits_i[4]));
    word_d = {byte2, byte1, byte0};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ rtl/nds_serializer.sv @@
// ----------------------------------------------------------------------------
// nds_serializer: 24-bit shift-out stage
// Loads a packed word and emits it LSB first, one beat per cycle, flagging
// the last beat with the store strobe. Reloads on the last beat.
// ----------------------------------------------------------------------------
module nds_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [nds_pkg::WordW-1:0] word_i,
  output logic                      out_valid_o,
  output logic                      serial_bit_o,
  output logic                      store_strobe_o
);
  import nds_pkg::*;

  logic             active_d, active_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic [WordW-1:0] shift_d, shift_q;
  logic             last;

  assign last    = active_q && (cnt_q == LastBit);
  assign ready_o = !active_q || last;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    if (ready_o && valid_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      shift_d  = word_i;
    end else if (active_q) begin
      active_d = !last;
      cnt_d    = cnt_q + CntW'(1);
      shift_d  = shift_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign out_valid_o    = active_q;
  assign serial_bit_o   = shift_q[0];
  assign store_strobe_o = last;

endmodule

@@ rtl/nixie_decimal_to_serial_code.sv @@
// ----------------------------------------------------------------------------
// nixie_decimal_to_serial_code: decimal digit driver code serializer
// Usage:
//   A value beat is taken at a clock edge where start is high and busy
//   is low. The block splits off the six lowest decimal digits, maps each to
//   its driver code, packs a 24-bit word and shifts it out LSB first.
//   Each result beat is on serial_bit_o / store_strobe_o for one cycle,
//   marked by out_valid_o; store_strobe_o is high on the 24th beat only.
//   The receiver cannot stall; every beat is taken when shown.
// Timing:
//   Five divide-by-ten stages and one code stage, each one register deep,
//   then the shift register. With the pipe empty, the first bit of a value is
//   on the ports once the value has passed through those registers; the 24
//   bits follow back to back.
//   Sustained rate is set by the one-bit-per-cycle shift register; the pipe
//   holds up to seven values, one of them shifting, and busy rises once it
//   is full.
// Reset:
//   rst_ni clears all valid bits and the shift counter; no beat is shown
//   until a value has been taken after reset.
// ----------------------------------------------------------------------------
module nixie_decimal_to_serial_code (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [nds_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  output logic                       serial_bit_o,
  output logic                       store_strobe_o
);
  import nds_pkg::*;

  logic    [NumDiv:0]  st_valid;
  logic    [NumDiv:0]  st_ready;
  logic    [ValueW-1:0] st_value [NumDiv+1];
  digits_t             st_digits [NumDiv+1];
  logic                enc_valid;
  logic                enc_ready;
  logic    [WordW-1:0] enc_word;

  assign st_valid[0]  = start;
  assign st_value[0]  = value_i;
  assign st_digits[0] = '0;
  assign busy         = !st_ready[0];

  for (genvar k = 0; k < NumDiv; k++) begin : g_div
    nds_div_stage u_div (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (st_valid[k]),
      .ready_o  (st_ready[k]),
      .value_i  (st_value[k]),
      .digits_i (st_digits[k]),
      .idx_i    (IdxW'(k)),
      .valid_o  (st_valid[k+1]),
      .ready_i  (st_ready[k+1]),
      .value_o  (st_value[k+1]),
      .digits_o (st_digits[k+1])
    );
  end

  nds_encode u_encode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (st_valid[NumDiv]),
    .ready_o  (st_ready[NumDiv]),
    .value_i  (st_value[NumDiv]),
    .digits_i (st_digits[NumDiv]),
    .valid_o  (enc_valid),
    .ready_i  (enc_ready),
    .word_o   (enc_word)
  );

  nds_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (enc_valid),
    .ready_o        (enc_ready),
    .word_i         (enc_word),
    .out_valid_o    (out_valid_o),
    .serial_bit_o   (serial_bit_o),
    .store_strobe_o (store_strobe_o)
  );

endmodule

@@ bench/nixie_decimal_to_serial_code_tb.sv @@
// ----------------------------------------------------------------------------
// nixie_decimal_to_serial_code_tb: regression for the digit code serializer
// Drives value beats through the start/busy handshake and predicts, for each
// accepted value, the 24 code bits and the store strobe. A checker at every
// rising edge pops the oldest expected bit for each result beat. Covered are
// the digit tables at every position, values past six digits, a full drain
// between bursts, and random values with random or no idle cycles.
// ----------------------------------------------------------------------------
module nixie_decimal_to_serial_code_tb;
  import nds_pkg::*;

  localparam int unsigned NumItems    = 480;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;

  // driver code per digit, digit 0 in the lowest nibble
  localparam logic [39:0] TubeCodes = {4'hC, 4'h1, 4'h5, 4'h7, 4'h3,
                                       4'h2, 4'h6, 4'h4, 4'h0, 4'h8};
  localparam logic [39:0] LeadCodes = {24'h000000, 4'h2, 4'h4, 4'h8, 4'h1};

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [4:0]        index;
    logic              serial_bit;
    logic              store_strobe;
  } code_bit_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] value_i;
  logic              out_valid_o;
  logic              serial_bit_o;
  logic              store_strobe_o;

  code_bit_t   pending_bits[$];
  int unsigned fail_count = 0;
  bit          back_to_back;

  nixie_decimal_to_serial_code u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .serial_bit_o  (serial_bit_o),
    .store_strobe_o(store_strobe_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] spread_code(input logic [3:0] c);
    return {c[3], 4'b0000, c[2:0]};
  endfunction

  function automatic logic [WordW-1:0] tube_word(input logic [ValueW-1:0] v);
    int unsigned rest;
    int          i;
    logic [3:0]  dig [6];
    logic [3:0]  c;
    logic [WordW-1:0] w;
    rest = v;
    for (i = 0; i < 6; i++) begin
      dig[i] = 4'(rest % Radix);
      rest   = rest / Radix;
    end
    c = TubeCodes[4*int'(dig[0]) +: 4];
    w[23:16] = spread_code({c[2], c[0], c[1], c[3]}) |
               {1'b0, TubeCodes[4*int'(dig[1]) +: 4], 3'b000};
    c = TubeCodes[4*int'(dig[2]) +: 4];
    w[15:8]  = spread_code({c[2], c[0], c[1], c[3]}) |
               {1'b0, TubeCodes[4*int'(dig[3]) +: 4], 3'b000};
    w[7:0]   = spread_code(LeadCodes[4*int'(dig[5]) +: 4]) |
               {1'b0, TubeCodes[4*int'(dig[4]) +: 4], 3'b000};
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MaxReports) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned      idle;
    int               i;
    logic [WordW-1:0] w;
    @(negedge clk_i);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    w = tube_word(v);
    for (i = 0; i < WordW; i++) begin
      pending_bits.push_back('{value: v, index: 5'(i), serial_bit: w[i],
                               store_strobe: (i == WordW - 1)});
    end
    idle = back_to_back ? 0 : $urandom_range(0, 4);
    if (idle != 0) begin
      @(negedge clk_i);
      start   <= 1'b0;
      value_i <= ValueW'($urandom);
      repeat (idle - 1) @(negedge clk_i);
    end
  endtask

  task automatic stop_stream();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic test_digit_tables();
    int unsigned corners [18] = '{0, 111111, 222222, 333333, 444444, 555555,
                                  666666, 777777, 888888, 999999, 1000000,
                                  1048575, 524288, 123456, 987654, 1, 10,
                                  1000009};
    int i;
    for (i = 0; i < 18; i++) send_value(ValueW'(corners[i]));
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 4; i++) send_value(ValueW'($urandom));
    stop_stream();
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    back_to_back = 1'b1;
    for (i = 0; i < 4; i++) send_value(ValueW'($urandom));
    back_to_back = 1'b0;
  endtask

  task automatic test_random_values();
    int unsigned       n;
    logic [ValueW-1:0] v;
    for (n = 0; n < NumItems; n++) begin
      if (n % 40 == 0) back_to_back = ((n / 40) % 3 == 2);
      case ($urandom_range(0, 3))
        0:       v = ValueW'($urandom);
        1:       v = ValueW'($urandom_range(0, 999999));
        2:       v = ValueW'($urandom_range(1000000, 1048575));
        default: v = ValueW'($urandom_range(0, 99));
      endcase
      send_value(v);
    end
    back_to_back = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    code_bit_t want;
    if (rst_ni && out_valid_o) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected beat bit=%0b strobe=%0b",
                                  serial_bit_o, store_strobe_o));
      end else begin
        want = pending_bits.pop_front();
        if (serial_bit_o !== want.serial_bit ||
            store_strobe_o !== want.store_strobe) begin
          report_mismatch($sformatf(
            "value %0d bit %0d: expected bit=%0b strobe=%0b, got bit=%0b strobe=%0b",
            want.value, want.index, want.serial_bit, want.store_strobe,
            serial_bit_o, store_strobe_o));
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    value_i      = '0;
    back_to_back = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_digit_tables();
    test_drain_pause();
    test_random_values();
    stop_stream();
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
